### hdl/wtd_pkg.sv
// ----------------------------------------------------------------------------
// wtd_pkg
// Shared widths, types and the binary-angle arctangent table.
// ----------------------------------------------------------------------------
package wtd_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int VEL_WIDTH   = COORD_WIDTH + 1;
  localparam int ACC_WIDTH   = COORD_WIDTH + 2;
  localparam int JRK_WIDTH   = COORD_WIDTH + 3;
  localparam int ANG_WIDTH   = 16;
  localparam int CORDIC_STEPS = 20;
  localparam int CW          = 44;   // cordic datapath width
  localparam int NORM_BIT    = 40;
  localparam int NORM_STAGES = 6;    // shift amounts 32,16,8,4,2,1

  // one point leaving the front end, derivatives in full
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [VEL_WIDTH-1:0]   vel_x;
    logic signed [VEL_WIDTH-1:0]   vel_y;
    logic signed [ACC_WIDTH-1:0]   acc_x;
    logic signed [ACC_WIDTH-1:0]   acc_y;
    logic signed [JRK_WIDTH-1:0]   jrk_x;
    logic signed [JRK_WIDTH-1:0]   jrk_y;
    logic                          final_flag;
  } wtd_point_t;

  // vector handed to one angle lane
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
    logic                 zero;
  } wtd_vec_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10680862;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hdl/wtd_front.sv
// ----------------------------------------------------------------------------
// wtd_front
// Four-point window: takes waypoints, forms differences and releases points,
// flushing one per cycle after a goal point while the queue has room.
// ----------------------------------------------------------------------------
module wtd_front
  import wtd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  input  logic                          in_last_point,
  output logic                          pt_valid,
  input  logic                          pt_ready,
  output wtd_pkg::wtd_point_t           pt_data
);

  logic signed [COORD_WIDTH-1:0] wx_r [4];
  logic signed [COORD_WIDTH-1:0] wy_r [4];
  logic signed [COORD_WIDTH-1:0] wx_nxt [4];
  logic signed [COORD_WIDTH-1:0] wy_nxt [4];
  logic [2:0] cnt_r, cnt_nxt;      // points held
  logic       flush_r, flush_nxt;  // draining after goal
  logic [2:0] k_r, k_nxt;          // path length while draining
  logic signed [VEL_WIDTH-1:0] lvx_r, lvx_nxt;  // velocity of the point before the goal
  logic signed [VEL_WIDTH-1:0] lvy_r, lvy_nxt;

  logic signed [VEL_WIDTH-1:0] vx [4];
  logic signed [VEL_WIDTH-1:0] vy [4];
  logic signed [ACC_WIDTH-1:0] ax [4];
  logic signed [ACC_WIDTH-1:0] ay [4];
  logic signed [JRK_WIDTH-1:0] jx, jy;
  logic [2:0] klen;
  logic [1:0] wr_idx;
  logic       accept, emit;

  assign in_full = flush_r || ((cnt_r == 3'd4) && !pt_ready);
  assign accept  = in_push && !in_full;
  assign klen    = flush_r ? k_r : 3'd4;
  assign wr_idx  = emit ? 2'(cnt_r - 3'd1) : cnt_r[1:0];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      vx[j] = VEL_WIDTH'(wx_r[j+1]) - VEL_WIDTH'(wx_r[j]);
      vy[j] = VEL_WIDTH'(wy_r[j+1]) - VEL_WIDTH'(wy_r[j]);
    end
    vx[3] = '0;
    vy[3] = '0;
    if (klen >= 3'd2) begin
      vx[klen[1:0]-2'd1] = vx[klen[1:0]-2'd2];
      vy[klen[1:0]-2'd1] = vy[klen[1:0]-2'd2];
    end
    for (int j = 0; j < 3; j++) begin
      ax[j] = ACC_WIDTH'(vx[j+1]) - ACC_WIDTH'(vx[j]);
      ay[j] = ACC_WIDTH'(vy[j+1]) - ACC_WIDTH'(vy[j]);
    end
    ax[3] = '0;
    ay[3] = '0;
    if (klen >= 3'd2) begin
      ax[klen[1:0]-2'd1] = ax[klen[1:0]-2'd2];
      ay[klen[1:0]-2'd1] = ay[klen[1:0]-2'd2];
    end
    // head jerk; a head that is last or next-to-last sees zero after copies
    jx = JRK_WIDTH'(ax[1]) - JRK_WIDTH'(ax[0]);
    jy = JRK_WIDTH'(ay[1]) - JRK_WIDTH'(ay[0]);
    if (klen <= 3'd2) begin
      jx = '0;
      jy = '0;
    end
  end

  assign pt_valid = flush_r || (cnt_r == 3'd4);
  assign emit     = pt_valid && pt_ready;

  always_comb begin
    pt_data.pos_x      = wx_r[0];
    pt_data.pos_y      = wy_r[0];
    pt_data.vel_x      = (klen == 3'd1) ? lvx_r : vx[0];
    pt_data.vel_y      = (klen == 3'd1) ? lvy_r : vy[0];
    pt_data.acc_x      = (klen == 3'd1) ? '0 : ax[0];
    pt_data.acc_y      = (klen == 3'd1) ? '0 : ay[0];
    pt_data.jrk_x      = jx;
    pt_data.jrk_y      = jy;
    pt_data.final_flag = flush_r && (k_r == 3'd1);
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      wx_nxt[j] = wx_r[j];
      wy_nxt[j] = wy_r[j];
    end
    cnt_nxt   = cnt_r;
    flush_nxt = flush_r;
    k_nxt     = k_r;
    lvx_nxt   = lvx_r;
    lvy_nxt   = lvy_r;
    if (emit) begin
      // advance the window
      for (int j = 0; j < 3; j++) begin
        wx_nxt[j] = wx_r[j+1];
        wy_nxt[j] = wy_r[j+1];
      end
      cnt_nxt = cnt_r - 3'd1;
      lvx_nxt = vx[0];
      lvy_nxt = vy[0];
      if (flush_r) begin
        k_nxt = k_r - 3'd1;
        if (k_r == 3'd1) begin
          flush_nxt = 1'b0;
          cnt_nxt   = '0;
          lvx_nxt   = '0;
          lvy_nxt   = '0;
        end
      end
    end
    if (accept) begin
      wx_nxt[wr_idx] = in_x_coord;
      wy_nxt[wr_idx] = in_y_coord;
      cnt_nxt = emit ? cnt_r : cnt_r + 3'd1;
      if (in_last_point) begin
        flush_nxt = 1'b1;
        k_nxt     = cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      wx_r[j] <= wx_nxt[j];
      wy_r[j] <= wy_nxt[j];
    end
    if (!rst_n) begin
      cnt_r   <= '0;
      flush_r <= 1'b0;
      k_r     <= '0;
      lvx_r   <= '0;
      lvy_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
      k_r     <= k_nxt;
      lvx_r   <= lvx_nxt;
      lvy_r   <= lvy_nxt;
    end
  end

endmodule

### hdl/wtd_fifo.sv
// ----------------------------------------------------------------------------
// wtd_fifo
// Two-entry queue of points between the window and the angle pipeline.
// ----------------------------------------------------------------------------
module wtd_fifo
  import wtd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  wtd_pkg::wtd_point_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output wtd_pkg::wtd_point_t rd_data
);

  wtd_point_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

### hdl/wtd_back.sv
// ----------------------------------------------------------------------------
// wtd_back
// Three-lane pipelined CORDIC for the headings, with a stalling shift
// pipeline, followed by a two-entry output queue.
// ----------------------------------------------------------------------------
module wtd_back
  import wtd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pt_valid,
  output logic                          pt_ready,
  input  wtd_pkg::wtd_point_t           pt_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [COORD_WIDTH-1:0] out_pos_x,
  output logic signed [COORD_WIDTH-1:0] out_pos_y,
  output logic signed [VEL_WIDTH-1:0]   out_vel_x,
  output logic signed [VEL_WIDTH-1:0]   out_vel_y,
  output logic signed [ANG_WIDTH-1:0]   out_heading,
  output logic signed [ACC_WIDTH-1:0]   out_acc_x,
  output logic signed [ACC_WIDTH-1:0]   out_acc_y,
  output logic signed [ANG_WIDTH-1:0]   out_acc_heading,
  output logic signed [ANG_WIDTH-1:0]   out_jerk_heading,
  output logic                          out_final_flag
);

  localparam int NST = 1 + NORM_STAGES + CORDIC_STEPS;  // pipeline stages

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [VEL_WIDTH-1:0]   vel_x;
    logic signed [VEL_WIDTH-1:0]   vel_y;
    logic signed [ACC_WIDTH-1:0]   acc_x;
    logic signed [ACC_WIDTH-1:0]   acc_y;
    logic                          final_flag;
  } side_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [VEL_WIDTH-1:0]   vel_x;
    logic signed [VEL_WIDTH-1:0]   vel_y;
    logic signed [ANG_WIDTH-1:0]   heading;
    logic signed [ACC_WIDTH-1:0]   acc_x;
    logic signed [ACC_WIDTH-1:0]   acc_y;
    logic signed [ANG_WIDTH-1:0]   acc_heading;
    logic signed [ANG_WIDTH-1:0]   jerk_heading;
    logic                          final_flag;
  } res_t;

  logic       vld_r [NST];
  side_t      side_r [NST];
  wtd_vec_t   lane_r [NST][3];
  wtd_vec_t   lane_nxt [NST][3];
  logic       adv;
  logic       q_ready;

  res_t       q_r [2];
  logic       qw_r, qr_r;
  logic [1:0] qc_r;
  res_t       res;
  logic       q_wr, q_rd;

  // vector in: rotate by pi when x is negative
  function automatic wtd_vec_t load(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y);
    wtd_vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      v.x = -x;
      v.y = -y;
      v.z = 32'h8000_0000;
    end else begin
      v.x = x;
      v.y = y;
      v.z = '0;
    end
    return v;
  endfunction

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] a);
    return (a < 0) ? -a : a;
  endfunction

  // shift left by sh while the larger magnitude stays below 2^(NORM_BIT+1)
  function automatic wtd_vec_t norm(input wtd_vec_t v, input int sh);
    wtd_vec_t   o;
    logic [CW-1:0] mx, my;
    o  = v;
    mx = mag(v.x);
    my = mag(v.y);
    if (!v.zero && ((mx | my) >> (NORM_BIT + 1 - sh)) == '0) begin
      o.x = v.x <<< sh;
      o.y = v.y <<< sh;
    end
    return o;
  endfunction

  function automatic wtd_vec_t rot(input wtd_vec_t v, input logic [4:0] i);
    wtd_vec_t o;
    o = v;
    if (v.y > 0) begin
      o.x = v.x + (v.y >>> i);
      o.y = v.y - (v.x >>> i);
      o.z = v.z + atan_entry(i);
    end else begin
      o.x = v.x - (v.y >>> i);
      o.y = v.y + (v.x >>> i);
      o.z = v.z - atan_entry(i);
    end
    return o;
  endfunction

  function automatic logic [ANG_WIDTH-1:0] ang(input wtd_vec_t v);
    logic [31:0] s;
    s = v.z + 32'h0000_8000;
    return v.zero ? '0 : s[31:16];
  endfunction

  assign adv      = !vld_r[NST-1] || q_ready;
  assign pt_ready = adv;

  always_comb begin
    lane_nxt[0][0] = load(CW'(pt_data.vel_x), CW'(pt_data.vel_y));
    lane_nxt[0][1] = load(CW'(pt_data.acc_x), CW'(pt_data.acc_y));
    lane_nxt[0][2] = load(CW'(pt_data.jrk_x), CW'(pt_data.jrk_y));
    for (int s = 1; s < NST; s++) begin
      for (int l = 0; l < 3; l++) begin
        if (s <= NORM_STAGES)
          lane_nxt[s][l] = norm(lane_r[s-1][l], 1 << (NORM_STAGES - s));
        else
          lane_nxt[s][l] = rot(lane_r[s-1][l], 5'(s - 1 - NORM_STAGES));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].pos_x      <= pt_data.pos_x;
      side_r[0].pos_y      <= pt_data.pos_y;
      side_r[0].vel_x      <= pt_data.vel_x;
      side_r[0].vel_y      <= pt_data.vel_y;
      side_r[0].acc_x      <= pt_data.acc_x;
      side_r[0].acc_y      <= pt_data.acc_y;
      side_r[0].final_flag <= pt_data.final_flag;
      for (int s = 1; s < NST; s++) side_r[s] <= side_r[s-1];
      for (int s = 0; s < NST; s++)
        for (int l = 0; l < 3; l++) lane_r[s][l] <= lane_nxt[s][l];
    end
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= pt_valid;
      for (int s = 1; s < NST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_comb begin
    res.pos_x        = side_r[NST-1].pos_x;
    res.pos_y        = side_r[NST-1].pos_y;
    res.vel_x        = side_r[NST-1].vel_x;
    res.vel_y        = side_r[NST-1].vel_y;
    res.acc_x        = side_r[NST-1].acc_x;
    res.acc_y        = side_r[NST-1].acc_y;
    res.final_flag   = side_r[NST-1].final_flag;
    res.heading      = ang(lane_r[NST-1][0]);
    res.acc_heading  = ang(lane_r[NST-1][1]);
    res.jerk_heading = ang(lane_r[NST-1][2]);
  end

  assign q_ready   = (qc_r != 2'd2);
  assign q_wr      = vld_r[NST-1] && q_ready;
  assign out_empty = (qc_r == 2'd0);
  assign q_rd      = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (q_wr) q_r[qw_r] <= res;
    if (!rst_n) begin
      qw_r <= 1'b0;
      qr_r <= 1'b0;
      qc_r <= '0;
    end else begin
      if (q_wr) qw_r <= !qw_r;
      if (q_rd) qr_r <= !qr_r;
      qc_r <= qc_r + {1'b0, q_wr} - {1'b0, q_rd};
    end
  end

  assign out_pos_x        = q_r[qr_r].pos_x;
  assign out_pos_y        = q_r[qr_r].pos_y;
  assign out_vel_x        = q_r[qr_r].vel_x;
  assign out_vel_y        = q_r[qr_r].vel_y;
  assign out_heading      = q_r[qr_r].heading;
  assign out_acc_x        = q_r[qr_r].acc_x;
  assign out_acc_y        = q_r[qr_r].acc_y;
  assign out_acc_heading  = q_r[qr_r].acc_heading;
  assign out_jerk_heading = q_r[qr_r].jerk_heading;
  assign out_final_flag   = q_r[qr_r].final_flag;

endmodule

### hdl/waypoint_trajectory_derivatives.sv
// ----------------------------------------------------------------------------
// waypoint_trajectory_derivatives
// Position, differences and headings of a waypoint stream.
// ----------------------------------------------------------------------------
// Path: a result reaches the ports through the window, the queue, the
// 27-stage CORDIC pipeline and the output queue. Input: one waypoint per
// cycle while the queue has room; a goal point blocks input until it is flushed.
// Reset: synchronous, active low; clears window fill, queues and pipeline.
module waypoint_trajectory_derivatives
  import wtd_pkg::*;
(
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic signed [wtd_pkg::COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [wtd_pkg::COORD_WIDTH-1:0] in_y_coord,
  input  logic                                   in_last_point,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [wtd_pkg::COORD_WIDTH-1:0] out_pos_x,
  output logic signed [wtd_pkg::COORD_WIDTH-1:0] out_pos_y,
  output logic signed [wtd_pkg::VEL_WIDTH-1:0]   out_vel_x,
  output logic signed [wtd_pkg::VEL_WIDTH-1:0]   out_vel_y,
  output logic signed [wtd_pkg::ANG_WIDTH-1:0]   out_heading,
  output logic signed [wtd_pkg::ACC_WIDTH-1:0]   out_acc_x,
  output logic signed [wtd_pkg::ACC_WIDTH-1:0]   out_acc_y,
  output logic signed [wtd_pkg::ANG_WIDTH-1:0]   out_acc_heading,
  output logic signed [wtd_pkg::ANG_WIDTH-1:0]   out_jerk_heading,
  output logic                                   out_final_flag
);

  logic       f_valid, f_ready, b_valid, b_ready;
  wtd_point_t f_data, b_data;

  wtd_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_x_coord, .in_y_coord, .in_last_point,
    .pt_valid(f_valid), .pt_ready(f_ready), .pt_data(f_data)
  );

  wtd_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  wtd_back u_back (
    .clk, .rst_n, .pt_valid(b_valid), .pt_ready(b_ready), .pt_data(b_data),
    .out_empty, .out_pop, .out_pos_x, .out_pos_y, .out_vel_x, .out_vel_y,
    .out_heading, .out_acc_x, .out_acc_y, .out_acc_heading, .out_jerk_heading,
    .out_final_flag
  );

  a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && !f_ready) |-> in_full)
    else $error("window took input while stalled");

  a_final_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && f_ready && f_data.final_flag) |=> !(f_valid && f_data.final_flag))
    else $error("goal point released twice");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

endmodule

### tb/sv/wtd_checker.sv
// ----------------------------------------------------------------------------
// wtd_checker
// Watches both channels of the waypoint derivative block, predicts every
// result word from the accepted waypoints and compares field by field.
// ----------------------------------------------------------------------------
module wtd_checker
  import wtd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  input  logic                          in_last_point,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  logic signed [COORD_WIDTH-1:0] out_pos_x,
  input  logic signed [COORD_WIDTH-1:0] out_pos_y,
  input  logic signed [VEL_WIDTH-1:0]   out_vel_x,
  input  logic signed [VEL_WIDTH-1:0]   out_vel_y,
  input  logic signed [ANG_WIDTH-1:0]   out_heading,
  input  logic signed [ACC_WIDTH-1:0]   out_acc_x,
  input  logic signed [ACC_WIDTH-1:0]   out_acc_y,
  input  logic signed [ANG_WIDTH-1:0]   out_acc_heading,
  input  logic signed [ANG_WIDTH-1:0]   out_jerk_heading,
  input  logic                          out_final_flag,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [VEL_WIDTH-1:0]   vel_x;
    logic signed [VEL_WIDTH-1:0]   vel_y;
    logic signed [ANG_WIDTH-1:0]   heading;
    logic signed [ACC_WIDTH-1:0]   acc_x;
    logic signed [ACC_WIDTH-1:0]   acc_y;
    logic signed [ANG_WIDTH-1:0]   acc_heading;
    logic signed [ANG_WIDTH-1:0]   jerk_heading;
    logic                          final_flag;
  } deriv_word_t;

  localparam logic [31:0] ATAN_LUT [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304};

  longint      win_x [4];
  longint      win_y [4];
  int          held;
  deriv_word_t expected_words [$];

  function automatic logic [ANG_WIDTH-1:0] heading_of(longint vy, longint vx);
    logic [31:0] ang;
    longint      m, nx, ny;
    ang = '0;
    if (vx == 0 && vy == 0) return '0;
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      ang = 32'h8000_0000;
    end
    m = (vx > (vy < 0 ? -vy : vy)) ? vx : (vy < 0 ? -vy : vy);
    while (m < (64'sd1 <<< 40)) begin
      vx = vx * 2;
      vy = vy * 2;
      m = m * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (vy > 0) begin
        nx = vx + (vy >>> i);
        ny = vy - (vx >>> i);
        ang = ang + ATAN_LUT[i];
      end else begin
        nx = vx - (vy >>> i);
        ny = vy + (vx >>> i);
        ang = ang - ATAN_LUT[i];
      end
      vx = nx;
      vy = ny;
    end
    ang = ang + 32'h8000;
    return ang[31:16];
  endfunction

  task automatic push_derivatives(input int k, input int count, input bit goal);
    longint vx [4], vy [4], ax [4], ay [4], jx [4], jy [4];
    deriv_word_t w;
    for (int j = 0; j < 4; j++) begin
      vx[j] = 0; vy[j] = 0; ax[j] = 0; ay[j] = 0; jx[j] = 0; jy[j] = 0;
    end
    for (int j = 0; j + 1 < k; j++) begin
      vx[j] = win_x[j+1] - win_x[j];
      vy[j] = win_y[j+1] - win_y[j];
    end
    if (k >= 2) begin
      vx[k-1] = vx[k-2]; vy[k-1] = vy[k-2];
    end
    for (int j = 0; j + 1 < k; j++) begin
      ax[j] = vx[j+1] - vx[j];
      ay[j] = vy[j+1] - vy[j];
    end
    if (k >= 2) begin
      ax[k-1] = ax[k-2]; ay[k-1] = ay[k-2];
    end
    for (int j = 0; j + 1 < k; j++) begin
      jx[j] = ax[j+1] - ax[j];
      jy[j] = ay[j+1] - ay[j];
    end
    if (k >= 2) begin
      jx[k-1] = jx[k-2]; jy[k-1] = jy[k-2];
    end
    for (int j = 0; j < count; j++) begin
      w.pos_x        = COORD_WIDTH'(win_x[j]);
      w.pos_y        = COORD_WIDTH'(win_y[j]);
      w.vel_x        = VEL_WIDTH'(vx[j]);
      w.vel_y        = VEL_WIDTH'(vy[j]);
      w.heading      = heading_of(vy[j], vx[j]);
      w.acc_x        = ACC_WIDTH'(ax[j]);
      w.acc_y        = ACC_WIDTH'(ay[j]);
      w.acc_heading  = heading_of(ay[j], ax[j]);
      w.jerk_heading = heading_of(jy[j], jx[j]);
      w.final_flag   = goal && (j + 1 == k);
      expected_words.push_back(w);
    end
  endtask

  task automatic accept_waypoint();
    int k;
    win_x[held] = in_x_coord;
    win_y[held] = in_y_coord;
    k = held + 1;
    if (in_last_point) begin
      push_derivatives(k, k, 1'b1);
      held = 0;
      for (int i = 0; i < 4; i++) begin
        win_x[i] = 0; win_y[i] = 0;
      end
    end else if (k < 4) begin
      held = k;
    end else begin
      push_derivatives(4, 1, 1'b0);
      for (int i = 0; i < 3; i++) begin
        win_x[i] = win_x[i+1]; win_y[i] = win_y[i+1];
      end
      win_x[3] = 0; win_y[3] = 0;
      held = 3;
    end
  endtask

  task automatic compare_word();
    deriv_word_t got, exp_w;
    got = '{out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_heading, out_acc_x,
            out_acc_y, out_acc_heading, out_jerk_heading, out_final_flag};
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word %p", $realtime, got);
      errors++;
      return;
    end
    exp_w = expected_words.pop_front();
    if (got.pos_x !== exp_w.pos_x || got.pos_y !== exp_w.pos_y
        || got.vel_x !== exp_w.vel_x || got.vel_y !== exp_w.vel_y
        || got.heading !== exp_w.heading || got.acc_x !== exp_w.acc_x
        || got.acc_y !== exp_w.acc_y || got.acc_heading !== exp_w.acc_heading
        || got.jerk_heading !== exp_w.jerk_heading
        || got.final_flag !== exp_w.final_flag) begin
      $display("%0t: mismatch expected %p actual %p", $realtime, exp_w, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) accept_waypoint();
      if (out_pop && !out_empty) compare_word();
    end
    pending = expected_words.size();
  end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives waypoint paths into the derivative block under several idling
// regimes and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wtd_pkg::*;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_push = 1'b0;
  logic                          in_full;
  logic signed [COORD_WIDTH-1:0] in_x_coord = '0;
  logic signed [COORD_WIDTH-1:0] in_y_coord = '0;
  logic                          in_last_point = 1'b0;
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  logic signed [COORD_WIDTH-1:0] out_pos_x, out_pos_y;
  logic signed [VEL_WIDTH-1:0]   out_vel_x, out_vel_y;
  logic signed [ANG_WIDTH-1:0]   out_heading, out_acc_heading, out_jerk_heading;
  logic signed [ACC_WIDTH-1:0]   out_acc_x, out_acc_y;
  logic                          out_final_flag;
  int                            errors, pending;
  int                            send_idle_pct = 0;
  int                            pop_stall_pct = 0;

  always #6 clk = ~clk;

  waypoint_trajectory_derivatives uut (.*);
  wtd_checker chk (.*);

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // push stays high after acceptance; the next idle gap or the caller drops it
  task automatic send_point(input logic [COORD_WIDTH-1:0] x,
                            input logic [COORD_WIDTH-1:0] y, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push       <= 1'b1;
    in_x_coord    <= x;
    in_y_coord    <= y;
    in_last_point <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  function automatic logic [COORD_WIDTH-1:0] pick_coord();
    case ($urandom_range(5))
      0: return COORD_WIDTH'($urandom);
      1: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      2: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      default: return COORD_WIDTH'($urandom_range(4000) - 2000);
    endcase
  endfunction

  task automatic send_path(input int len);
    for (int i = 0; i < len; i++) send_point(pick_coord(), pick_coord(), i == len - 1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: single, short and extreme paths
    send_point(24'h7FFFFF, 24'h800000, 1'b1);
    send_point('0, '0, 1'b1);
    send_point(24'h800000, 24'h7FFFFF, 1'b0);
    send_point(24'h7FFFFF, 24'h800000, 1'b1);
    send_point(24'd10, '0, 1'b0);
    send_point('0, 24'd10, 1'b0);
    send_point(-24'sd10, -24'sd10, 1'b1);
    send_point(24'h800000, 24'h800000, 1'b0);
    send_point(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_point(24'h800000, 24'h800000, 1'b0);
    send_point(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_point(24'h800000, 24'h7FFFFF, 1'b1);
    send_point('0, '0, 1'b0);
    send_point('0, '0, 1'b0);
    send_point('0, '0, 1'b0);
    send_point('0, '0, 1'b0);
    send_point(24'd256, -24'sd256, 1'b1);
    // hold until drained
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 64 : 25) : 0;
      pop_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 64 : 25) : 0;
      for (int n = 0; n < 35; ) begin
        int len;
        len = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
        send_path(len);
        n += len;
      end
    end
    in_push <= 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
